FILE: rtl/core/sule_pkg.sv
// Package for the sorted unique list engine.
// Holds payload widths, the operation codes and the per-cell control struct.
// No dependencies.
package sule_pkg;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 7;
  localparam int COUNT_W  = 7;

  // Operation carried by one input item
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_FIND     = 2'd2,
    ACT_RETRIEVE = 2'd3
  } action_t;

  // Update command broadcast to every cell
  typedef struct packed {
    logic ins;   // shift up from the insert point, key lands there
    logic rem;   // shift down from the matching entry
  } cell_ctrl_t;

endpackage

FILE: rtl/core/sule_if.sv
// Valid/ready channel interfaces for the sorted unique list engine.
// Depends on sule_pkg for the payload widths and the operation type.
interface sule_in_if;
  import sule_pkg::*;

  logic                      valid;
  logic                      ready;
  action_t                   action;
  logic signed [VALUE_W-1:0] item_value;
  logic [SLOT_W-1:0]         slot_number;

  modport source (output valid, action, item_value, slot_number, input ready);
  modport sink   (input valid, action, item_value, slot_number, output ready);
endinterface

interface sule_out_if;
  import sule_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [SLOT_W-1:0]         found_position;
  logic signed [VALUE_W-1:0] data_out;
  logic [COUNT_W-1:0]        entry_count;
  logic                      is_empty;

  modport source (output valid, ok, found_position, data_out, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, ok, found_position, data_out, entry_count, is_empty,
                  output ready);
endinterface

FILE: rtl/core/sorted_unique_list_engine.sv
// Sorted unique list engine: a row of DEPTH compare-and-shift cells.
// An item passes from input transfer through the operation register, then the cell row,
// in which every cell compares and shifts, into the output register, where its result is valid.
// Throughput: one item per cycle unless the output stalls; the whole row updates at once.
// Reset (rst_n low, synchronous) clears the entry count and both handshake stages;
// entry storage is not cleared and needs no clearing pass.
module sorted_unique_list_engine #(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  sule_in_if.sink      in_ch,
  sule_out_if.source   out_ch
);
  import sule_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SEL_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  // Operation stage
  logic                  op_vld_r;
  action_t               op_act_r;
  logic [ITEM_WIDTH-1:0] op_key_r;
  logic [SLOT_W-1:0]     op_slot_r;

  // List state
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;

  // Output stage
  logic                  out_vld_r;
  logic                  out_ok_r;
  logic [SLOT_W-1:0]     out_pos_r;
  logic [VALUE_W-1:0]    out_data_r;
  logic [COUNT_W-1:0]    out_cnt_r;
  logic                  out_empty_r;

  // Cell row signals
  logic [DEPTH-1:0]      lt_vec;
  logic [DEPTH-1:0]      eq_vec;
  logic [DEPTH-1:0]      vld_vec;
  logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ITEM_WIDTH-1:0] cell_rd   [DEPTH];
  cell_ctrl_t            ctrl;

  logic                  exec;
  logic                  hit;
  logic                  full;
  logic                  ins_ok;
  logic                  rem_ok;
  logic                  find_ok;
  logic                  rd_ok;
  logic [CNT_W-1:0]      hit_pos;
  logic [ITEM_WIDTH-1:0] rd_raw;
  logic signed [63:0]    rd_ext;
  logic [VALUE_W-1:0]    res_data;

  // Handshake: the operation stage drains whenever the output stage can take it
  assign exec         = op_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !op_vld_r || exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      op_vld_r <= 1'b1;
    end else if (exec) begin
      op_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_act_r  <= in_ch.action;
      op_key_r  <= ITEM_WIDTH'($unsigned(in_ch.item_value));
      op_slot_r <= in_ch.slot_number;
    end
  end

  // Cell row
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                  p_lt;
      logic [ITEM_WIDTH-1:0] p_data;
      logic [ITEM_WIDTH-1:0] n_data;

      assign vld_vec[gi] = (CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_first
        assign p_lt   = 1'b1;
        assign p_data = op_key_r;
      end else begin : g_mid
        assign p_lt   = lt_vec[gi-1];
        assign p_data = cell_data[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign n_data = cell_data[gi];
      end else begin : g_inner
        assign n_data = cell_data[gi+1];
      end

      sule_cell #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH),
        .IDX        (gi)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .key       (op_key_r),
        .slot      (op_slot_r),
        .vld       (vld_vec[gi]),
        .prev_lt   (p_lt),
        .prev_data (p_data),
        .next_data (n_data),
        .lt        (lt_vec[gi]),
        .eq        (eq_vec[gi]),
        .data      (cell_data[gi]),
        .rd_data   (cell_rd[gi])
      );
    end
  endgenerate

  // Match position and retrieve data gathered from the row
  always_comb begin
    hit_pos = '0;
    rd_raw  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eq_vec[i]) begin
        hit_pos = hit_pos | CNT_W'(i + 1);
      end
      rd_raw = rd_raw | cell_rd[i];
    end
  end

  assign hit     = |eq_vec;
  assign full    = (count_r == CNT_W'(DEPTH));
  assign ins_ok  = (op_act_r == ACT_INSERT) && !hit && !full;
  assign rem_ok  = (op_act_r == ACT_REMOVE) && hit;
  assign find_ok = (op_act_r == ACT_FIND) && hit;
  assign rd_ok   = (op_act_r == ACT_RETRIEVE) && (op_slot_r != '0)
                   && (SEL_W'(op_slot_r) <= SEL_W'(count_r));

  assign ctrl.ins = exec && ins_ok;
  assign ctrl.rem = exec && rem_ok;

  // Sign-extend the stored entry to the data port
  assign rd_ext   = 64'($signed(rd_raw));
  assign res_data = rd_ok ? rd_ext[VALUE_W-1:0] : '0;

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (exec) begin
      count_r <= count_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_ok_r    <= ins_ok || rem_ok || find_ok || rd_ok;
      out_pos_r   <= find_ok ? SLOT_W'(hit_pos) : '0;
      out_data_r  <= res_data;
      out_cnt_r   <= COUNT_W'(count_nxt);
      out_empty_r <= (count_nxt == '0);
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.found_position = out_pos_r;
  assign out_ch.data_out       = out_data_r;
  assign out_ch.entry_count    = out_cnt_r;
  assign out_ch.is_empty       = out_empty_r;

endmodule

FILE: rtl/core/sule_cell.sv
// One slot of the sorted list: holds an entry, compares it with the key and
// takes its neighbor's entry on insert or remove. Depends on sule_pkg.
module sule_cell #(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                                 clk,
  input  sule_pkg::cell_ctrl_t                 ctrl,
  input  logic [ITEM_WIDTH-1:0]                key,
  input  logic [sule_pkg::SLOT_W-1:0]          slot,
  input  logic                                 vld,
  input  logic                                 prev_lt,
  input  logic [ITEM_WIDTH-1:0]                prev_data,
  input  logic [ITEM_WIDTH-1:0]                next_data,
  output logic                                 lt,
  output logic                                 eq,
  output logic [ITEM_WIDTH-1:0]                data,
  output logic [ITEM_WIDTH-1:0]                rd_data
);
  import sule_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SEL_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  logic [ITEM_WIDTH-1:0] data_r;
  logic [ITEM_WIDTH-1:0] data_nxt;
  logic                  sel;

  assign data = data_r;

  // Signed compare against the broadcast key, only for held entries
  assign lt = vld && ($signed(data_r) < $signed(key));
  assign eq = vld && (data_r == key);

  // Retrieve select: this cell sits at 1-based position IDX+1
  assign sel     = (SEL_W'(slot) == SEL_W'(IDX + 1));
  assign rd_data = sel ? data_r : '0;

  // Shift rules: cells at or past the insert/remove point move
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins && !lt) begin
      data_nxt = prev_lt ? key : prev_data;
    end else if (ctrl.rem && !lt) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: sim/tb_sorted_unique_list_engine.sv
`timescale 1ns / 1ps
// Testbench for sorted_unique_list_engine: directed and random list operations,
// each result checked field by field against an in-bench model of the sorted list.
// Depends on sule_pkg, sule_if.sv and the engine RTL.
module tb_sorted_unique_list_engine;
  import sule_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct {
    action_t                   act;
    logic signed [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]         slot;
  } list_op_t;

  typedef struct packed {
    logic                      ok;
    logic [SLOT_W-1:0]         position;
    logic signed [VALUE_W-1:0] data;
    logic [COUNT_W-1:0]        count;
    logic                      empty;
  } list_reply_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} op_mix_t;
  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst_n;

  sule_in_if  in_if();
  sule_out_if out_if();

  sorted_unique_list_engine #(.DEPTH(LIST_DEPTH), .ITEM_WIDTH(VALUE_W)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  list_op_t    op_queue[$];
  list_reply_t reply_queue[$];

  // Shadow copy of the sorted list
  logic signed [VALUE_W-1:0] shadow_list [LIST_DEPTH];
  int                        shadow_count = 0;

  int error_count = 0;
  int reply_index = 0;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] result %0d: %s", $realtime, reply_index, msg);
  endtask

  // Apply one accepted operation to the shadow list and queue the reply it owes
  task automatic track_operation(input action_t act, input logic signed [VALUE_W-1:0] key,
                                 input logic [SLOT_W-1:0] slot);
    list_reply_t r;
    int          idx;
    logic        hit;
    r   = '0;
    idx = 0;
    while (idx < shadow_count && shadow_list[idx] < key) idx++;
    hit = (idx < shadow_count) && (shadow_list[idx] == key);
    case (act)
      ACT_INSERT: begin
        if (!hit && shadow_count < LIST_DEPTH) begin
          for (int j = shadow_count; j > idx; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[idx] = key;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          for (int j = idx; j + 1 < shadow_count; j++) shadow_list[j] = shadow_list[j+1];
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      ACT_FIND: begin
        if (hit) begin
          r.ok       = 1'b1;
          r.position = SLOT_W'(idx + 1);
        end
      end
      default: begin
        if (slot >= 1 && slot <= shadow_count) begin
          r.ok   = 1'b1;
          r.data = shadow_list[slot-1];
        end
      end
    endcase
    r.count = COUNT_W'(shadow_count);
    r.empty = (shadow_count == 0);
    reply_queue.push_back(r);
  endtask

  task automatic queue_op(input action_t act, input logic signed [VALUE_W-1:0] value,
                          input logic [SLOT_W-1:0] slot);
    list_op_t op;
    op.act   = act;
    op.value = value;
    op.slot  = slot;
    op_queue.push_back(op);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        track_operation(in_if.action, in_if.item_value, in_if.slot_number);
      if (in_if.valid && !in_if.ready) begin
        // hold the current item until it transfers
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (op_queue.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid       <= 1'b1;
        in_if.action      <= op_queue[0].act;
        in_if.item_value  <= op_queue[0].value;
        in_if.slot_number <= op_queue[0].slot;
        void'(op_queue.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // Receiver: phases of always-ready, random stalls and a rotating stall pattern
  int          rx_phase_left = 0;
  rx_mode_t    rx_mode       = RX_OPEN;
  logic [15:0] rx_pattern    = 16'h0001;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 2));
        rx_phase_left = $urandom_range(20, 200);
        rx_pattern    = 16'($urandom) | 16'h0001;
      end
      rx_phase_left--;
      rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
        default:   out_if.ready <= rx_pattern[0];
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    list_reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (reply_queue.size() == 0) begin
        report_mismatch("result with no operation outstanding");
      end else begin
        want = reply_queue.pop_front();
        if (out_if.ok !== want.ok)
          report_mismatch($sformatf("ok %0b, expected %0b", out_if.ok, want.ok));
        if (out_if.found_position !== want.position)
          report_mismatch($sformatf("found_position %0d, expected %0d",
                                    out_if.found_position, want.position));
        if (out_if.data_out !== want.data)
          report_mismatch($sformatf("data_out %0d, expected %0d", out_if.data_out, want.data));
        if (out_if.entry_count !== want.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    out_if.entry_count, want.count));
        if (out_if.is_empty !== want.empty)
          report_mismatch($sformatf("is_empty %0b, expected %0b", out_if.is_empty, want.empty));
      end
      reply_index++;
    end
  end

  // Watchdog: cycles without any transfer
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sorted_unique_list_engine test failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic signed [VALUE_W-1:0] value_pool[$];
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] min_val;
    logic signed [VALUE_W-1:0] max_val;
    logic [SLOT_W-1:0]         slot;
    action_t                   act;
    op_mix_t                   mix;
    int                        total;
    int                        round_len;
    int                        pool_size;
    int                        pick;
    int                        round_no;

    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_INSERT;
    in_if.item_value   = '0;
    in_if.slot_number  = '0;
    out_if.ready       = 1'b0;
    min_val            = {1'b1, {(VALUE_W-1){1'b0}}};
    max_val            = {1'b0, {(VALUE_W-1){1'b1}}};

    // Directed: empty list, extremes, duplicates, bad slots, absent values
    queue_op(ACT_FIND,     32'sd5,  '0);
    queue_op(ACT_RETRIEVE, '0,      7'd0);
    queue_op(ACT_RETRIEVE, '0,      7'd1);
    queue_op(ACT_REMOVE,   32'sd7,  '0);
    queue_op(ACT_INSERT,   32'sd0,  '0);
    queue_op(ACT_INSERT,   min_val, '0);
    queue_op(ACT_INSERT,   max_val, '0);
    queue_op(ACT_INSERT,   -32'sd1, '0);
    queue_op(ACT_INSERT,   32'sd1,  '0);
    queue_op(ACT_INSERT,   32'sd0,  '0);
    queue_op(ACT_FIND,     min_val, '0);
    queue_op(ACT_FIND,     max_val, '0);
    queue_op(ACT_FIND,     32'sd2,  '0);
    queue_op(ACT_RETRIEVE, '0,      7'd1);
    queue_op(ACT_RETRIEVE, '0,      7'd5);
    queue_op(ACT_RETRIEVE, '0,      7'd6);
    queue_op(ACT_RETRIEVE, '0,      7'd127);
    queue_op(ACT_RETRIEVE, '0,      7'd0);
    queue_op(ACT_REMOVE,   min_val, '0);
    queue_op(ACT_REMOVE,   max_val, '0);
    queue_op(ACT_REMOVE,   max_val, '0);
    queue_op(ACT_FIND,     -32'sd1, '0);
    queue_op(ACT_REMOVE,   32'sd0,  '0);
    queue_op(ACT_REMOVE,   -32'sd1, '0);
    queue_op(ACT_REMOVE,   32'sd1,  '0);

    // Random rounds; each draws values from a small pool so hits and duplicates are common
    total    = 0;
    round_no = 0;
    while (total < RANDOM_ITEMS) begin
      if (round_no == 0) begin
        mix       = MIX_FILL;
        pool_size = 96;
        round_len = 200;
      end else begin
        mix       = op_mix_t'($urandom_range(0, 3));
        pool_size = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : $urandom_range(64, 96);
        round_len = $urandom_range(40, 160);
      end
      value_pool.delete();
      for (int i = 0; i < pool_size; i++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       value_pool.push_back(($urandom_range(0, 1) == 0) ? min_val : max_val);
          1:       value_pool.push_back(($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1);
          2, 3, 4: value_pool.push_back($signed(32'($urandom_range(0, 40))) - 32'sd20);
          default: value_pool.push_back($signed($urandom));
        endcase
      end
      for (int i = 0; i < round_len; i++) begin
        pick = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  act = (pick < 60) ? ACT_INSERT : (pick < 70) ? ACT_REMOVE :
                           (pick < 85) ? ACT_FIND : ACT_RETRIEVE;
          MIX_DRAIN: act = (pick < 60) ? ACT_REMOVE : (pick < 70) ? ACT_INSERT :
                           (pick < 85) ? ACT_FIND : ACT_RETRIEVE;
          MIX_BALANCED: act = (pick < 30) ? ACT_INSERT : (pick < 55) ? ACT_REMOVE :
                              (pick < 80) ? ACT_FIND : ACT_RETRIEVE;
          default:   act = action_t'($urandom_range(0, 3));
        endcase
        if (mix == MIX_NOISE || $urandom_range(0, 9) == 0)
          value = $signed($urandom);
        else
          value = value_pool[$urandom_range(0, pool_size - 1)];
        if (mix == MIX_NOISE || $urandom_range(0, 4) == 0)
          slot = SLOT_W'($urandom_range(0, 127));
        else
          slot = SLOT_W'($urandom_range(0, LIST_DEPTH + 1));
        queue_op(act, value, slot);
      end
      total += round_len;
      round_no++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every operation to transfer and every result to come back
    while (op_queue.size() != 0 || in_if.valid) @(posedge clk);
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("sorted_unique_list_engine test passed");
    end else begin
      $display("sorted_unique_list_engine test failed");
    end
    $finish;
  end

endmodule
